@@ hdl/ttrad_pkg.sv @@
// Package: shared types, codes and reset values for the teletext row attribute decoder.
`timescale 1ns / 1ps
`default_nettype none

package ttrad_pkg;

  // Byte range of the attribute control codes.
  localparam logic [7:0] CTRL_LO = 8'h80;
  localparam logic [7:0] CTRL_HI = 8'h9F;

  // Control codes that act on their own.
  localparam logic [7:0] CODE_FLASH      = 8'h88;
  localparam logic [7:0] CODE_STEADY     = 8'h89;
  localparam logic [7:0] CODE_CONTIGUOUS = 8'h99;
  localparam logic [7:0] CODE_SEPARATED  = 8'h9A;
  localparam logic [7:0] CODE_BLACK_BG   = 8'h9C;
  localparam logic [7:0] CODE_NEW_BG     = 8'h9D;
  localparam logic [7:0] CODE_HOLD       = 8'h9E;
  localparam logic [7:0] CODE_RELEASE    = 8'h9F;

  // Codes 0x40-0x5F stay text in mosaic mode.
  localparam logic [7:0] BLAST_LO = 8'h40;
  localparam logic [7:0] BLAST_HI = 8'h5F;

  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] COLOUR_BLACK = 3'd0;
  localparam logic [2:0] COLOUR_WHITE = 3'd7;

  // Serial attribute state carried from cell to cell.
  typedef struct packed {
    logic [2:0] next_fg;
    logic [2:0] next_bg;
    logic       mosaic_mode;
    logic       sep_mode;
    logic       hold_mode;
    logic [7:0] held_char;
    logic       flash_mode;
  } attr_state_t;

  // One decoded cell.
  typedef struct packed {
    logic [2:0] fg_colour;
    logic [2:0] bg_colour;
    logic       mosaic_glyph;
    logic       separated;
    logic       flash_on;
    logic [7:0] shown_code;
  } cell_result_t;

  localparam attr_state_t ROW_RESET_STATE = '{
    next_fg:     COLOUR_WHITE,
    next_bg:     COLOUR_BLACK,
    mosaic_mode: 1'b0,
    sep_mode:    1'b0,
    hold_mode:   1'b0,
    held_char:   CHAR_SPACE,
    flash_mode:  1'b0
  };

endpackage

`default_nettype wire

@@ hdl/ttrad_decode.sv @@
// Combinational decode of one cell byte against the current serial attribute state.
`timescale 1ns / 1ps
`default_nettype none

module ttrad_decode (
  input  wire logic [7:0]             char_code,
  input  wire logic                   row_start,
  input  wire logic                   black_fg_enable,
  input  wire ttrad_pkg::attr_state_t cur_state,
  output ttrad_pkg::attr_state_t      nxt_state,
  output ttrad_pkg::cell_result_t     result
);

  ttrad_pkg::attr_state_t st;
  ttrad_pkg::attr_state_t upd;
  logic                   is_ctrl;
  logic                   flash_after;
  logic                   release_after;
  logic [2:0]             fg;
  logic [2:0]             bg;
  logic [7:0]             shown;
  logic                   glyph;

  always_comb begin
    // A row start clears the attributes before this cell is decoded.
    st            = row_start ? ttrad_pkg::ROW_RESET_STATE : cur_state;
    upd           = st;
    fg            = st.next_fg;
    bg            = st.next_bg;
    flash_after   = 1'b0;
    release_after = 1'b0;
    is_ctrl       = (char_code >= ttrad_pkg::CTRL_LO) && (char_code <= ttrad_pkg::CTRL_HI);

    // Attribute controls: colour selects act on the next cell, mode on this one.
    if (is_ctrl) begin
      if (!char_code[3]) begin
        if ((char_code[2:0] != ttrad_pkg::COLOUR_BLACK) || black_fg_enable) begin
          upd.next_fg = char_code[2:0];
        end
        upd.mosaic_mode = char_code[4];
      end else begin
        unique case (char_code)
          ttrad_pkg::CODE_FLASH:      flash_after = 1'b1;
          ttrad_pkg::CODE_STEADY:     upd.flash_mode = 1'b0;
          ttrad_pkg::CODE_CONTIGUOUS: upd.sep_mode = 1'b0;
          ttrad_pkg::CODE_SEPARATED:  upd.sep_mode = 1'b1;
          ttrad_pkg::CODE_BLACK_BG: begin
            bg          = ttrad_pkg::COLOUR_BLACK;
            upd.next_bg = ttrad_pkg::COLOUR_BLACK;
          end
          ttrad_pkg::CODE_NEW_BG: begin
            bg          = fg;
            upd.next_bg = fg;
          end
          ttrad_pkg::CODE_HOLD:       upd.hold_mode = 1'b1;
          ttrad_pkg::CODE_RELEASE:    release_after = 1'b1;
          default: ;
        endcase
      end
      shown = upd.hold_mode ? upd.held_char : ttrad_pkg::CHAR_SPACE;
    end else begin
      shown = char_code;
    end

    // Mosaic cells, except the blast-through range, feed the held character while hold is on.
    glyph = 1'b0;
    if (upd.mosaic_mode && ((shown < ttrad_pkg::BLAST_LO) || (shown > ttrad_pkg::BLAST_HI))) begin
      glyph = 1'b1;
      if (upd.hold_mode) begin
        upd.held_char = shown;
      end
    end

    result.fg_colour    = fg;
    result.bg_colour    = bg;
    result.mosaic_glyph = glyph;
    result.separated    = upd.sep_mode;
    result.flash_on     = upd.flash_mode;
    result.shown_code   = shown;

    // Set-after attributes take effect once this cell has been shown.
    nxt_state = upd;
    if (flash_after) begin
      nxt_state.flash_mode = 1'b1;
    end
    if (release_after) begin
      nxt_state.hold_mode = 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ hdl/teletext_row_attribute_decoder_core.sv @@
// Top level: input register, attribute state, decode and result register.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid, in_stall, in_char_code, in_row_start | request in
//  out     | out_valid, out_stall, out_* cell fields        | request out
//  cfg     | cfg_valid, cfg_ready, cfg_black_fg_enable      | write in
//
// One request is accepted every cycle while the output side keeps taking results.
// An accepted request waits in the input register while the decode path feeds the result
// register, which then presents the result on the out ports until it is taken.
// A stall on the output holds both registers; in_stall then rises once the input
// register is full. Reset (synchronous, rst_n low) empties both stages, restores the
// row attribute state and clears black_fg_enable. cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module teletext_row_attribute_decoder_core (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_char_code,
  input  wire logic       in_row_start,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_fg_colour,
  output logic [2:0]      out_bg_colour,
  output logic            out_mosaic_glyph,
  output logic            out_separated,
  output logic            out_flash_on,
  output logic [7:0]      out_shown_code,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_black_fg_enable
);

  logic                    in_valid_r;
  logic [7:0]              char_code_r;
  logic                    row_start_r;
  logic                    out_valid_r;
  logic                    black_fg_enable_r;
  ttrad_pkg::attr_state_t  state_r;
  ttrad_pkg::attr_state_t  state_nxt;
  ttrad_pkg::cell_result_t result_r;
  ttrad_pkg::cell_result_t result_nxt;
  logic                    advance;
  logic                    in_take;

  // Pipeline flow: the decode stage moves when the result register is empty or its result is taken.
  assign advance   = in_valid_r && (!out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign in_take   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  ttrad_decode u_decode (
    .char_code       (char_code_r),
    .row_start       (row_start_r),
    .black_fg_enable (black_fg_enable_r),
    .cur_state       (state_r),
    .nxt_state       (state_nxt),
    .result          (result_nxt)
  );

  // Control state, attribute state and configuration.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r        <= 1'b0;
      out_valid_r       <= 1'b0;
      black_fg_enable_r <= 1'b0;
      state_r           <= ttrad_pkg::ROW_RESET_STATE;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (advance) begin
        in_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        black_fg_enable_r <= cfg_black_fg_enable;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_take) begin
      char_code_r <= in_char_code;
      row_start_r <= in_row_start;
    end
    if (advance) begin
      result_r <= result_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_fg_colour    = result_r.fg_colour;
  assign out_bg_colour    = result_r.bg_colour;
  assign out_mosaic_glyph = result_r.mosaic_glyph;
  assign out_separated    = result_r.separated;
  assign out_flash_on     = result_r.flash_on;
  assign out_shown_code   = result_r.shown_code;

endmodule

`default_nettype wire

@@ hdl/ttrad_checker.sv @@
// Checker: port-level assertions for the teletext row attribute decoder, with its bind.
`timescale 1ns / 1ps
`default_nettype none

module ttrad_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       out_mosaic_glyph,
  input wire logic [7:0] out_shown_code,
  input wire logic       cfg_valid,
  input wire logic       cfg_ready
);

  // A stalled result stays presented and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shown_code))
    else $error("stalled result changed or dropped");

  // Blast-through codes are never drawn as mosaics.
  a_blast: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_mosaic_glyph |->
      (out_shown_code < ttrad_pkg::BLAST_LO) || (out_shown_code > ttrad_pkg::BLAST_HI))
    else $error("mosaic glyph on a blast-through code");

  // Reset leaves the output empty and the input side not stalled.
  a_reset_empty: assert property (@(posedge clk)
    rst_n && !$past(rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

  // With no result waiting, the input side is never held off.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled while output stage is empty");

  // The configuration port always takes a write.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write refused");

endmodule

bind teletext_row_attribute_decoder_core ttrad_checker u_ttrad_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_mosaic_glyph (out_mosaic_glyph),
  .out_shown_code   (out_shown_code),
  .cfg_valid        (cfg_valid),
  .cfg_ready        (cfg_ready)
);

`default_nettype wire
